// File: src/interval_resource_allocator_unit_assert.svh
// assertion helpers
`ifndef INTERVAL_RESOURCE_ALLOCATOR_UNIT_ASSERT_SVH
`define INTERVAL_RESOURCE_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define IRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ira check failed");

// next-cycle implication
`define IRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ira check failed");

`endif

// File: src/ira_pkg.sv
package ira_pkg;

	localparam int RESOURCES_DEF  = 2;
	localparam int TIME_BITS_DEF  = 32;
	localparam int INDEX_BITS_DEF = 16;
	localparam int ID_BITS_DEF    = (RESOURCES_DEF > 1) ? $clog2(RESOURCES_DEF) : 1;

	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} state_t;

	typedef enum logic [1:0] {
		BOP_HOLD,
		BOP_CLEAR,
		BOP_SHIFT,
		BOP_INSERT
	} busy_op_t;

	typedef enum logic [1:0] {
		SOP_HOLD,
		SOP_RESTART,
		SOP_PUSH,
		SOP_POP
	} stk_op_t;

	typedef struct packed {
		logic valid;
		logic place;
	} busy_stat_t;

endpackage

// File: src/ira_if.sv
interface ira_req_if #(
	parameter int TIME_BITS  = ira_pkg::TIME_BITS_DEF,
	parameter int INDEX_BITS = ira_pkg::INDEX_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  first_of_set;
	logic [TIME_BITS-1:0]  span_start;
	logic [TIME_BITS-1:0]  span_end;
	logic [INDEX_BITS-1:0] item_index;

	modport source (output valid, first_of_set, span_start, span_end, item_index,
		input ready);
	modport sink (input valid, first_of_set, span_start, span_end, item_index,
		output ready);
endinterface

interface ira_rsp_if #(
	parameter int INDEX_BITS = ira_pkg::INDEX_BITS_DEF,
	parameter int ID_BITS    = ira_pkg::ID_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] result_index;
	logic [ID_BITS-1:0]    resource_id;
	logic                  impossible;

	modport source (output valid, result_index, resource_id, impossible, input ready);
	modport sink (input valid, result_index, resource_id, impossible, output ready);
endinterface

// File: src/ira_busy_cell.sv
module ira_busy_cell #(
	parameter int TIME_BITS = ira_pkg::TIME_BITS_DEF,
	parameter int ID_BITS   = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ira_pkg::busy_op_t       op,
	input  logic [TIME_BITS-1:0]    new_end,
	input  logic [ID_BITS-1:0]      new_owner,
	input  ira_pkg::busy_stat_t     prev_stat,
	input  logic [TIME_BITS-1:0]    prev_end,
	input  logic [ID_BITS-1:0]      prev_owner,
	input  logic                    next_valid,
	input  logic [TIME_BITS-1:0]    next_end,
	input  logic [ID_BITS-1:0]      next_owner,
	output ira_pkg::busy_stat_t     stat,
	output logic [TIME_BITS-1:0]    busy_end,
	output logic [ID_BITS-1:0]      busy_owner
);

	logic                 valid_q;
	logic [TIME_BITS-1:0] end_q;
	logic [ID_BITS-1:0]   owner_q;

	// at or after the insert point: empty, or ends later than the new item
	assign stat.valid = valid_q;
	assign stat.place = !valid_q || (end_q > new_end);
	assign busy_end   = end_q;
	assign busy_owner = owner_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (op)
				ira_pkg::BOP_CLEAR:  valid_q <= 1'b0;
				ira_pkg::BOP_SHIFT:  valid_q <= next_valid;
				ira_pkg::BOP_INSERT: begin
					if (stat.place) begin
						valid_q <= prev_stat.place ? prev_stat.valid : 1'b1;
					end
				end
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			ira_pkg::BOP_SHIFT: begin
				end_q   <= next_end;
				owner_q <= next_owner;
			end
			ira_pkg::BOP_INSERT: begin
				if (stat.place) begin
					end_q   <= prev_stat.place ? prev_end : new_end;
					owner_q <= prev_stat.place ? prev_owner : new_owner;
				end
			end
			default: begin
				end_q   <= end_q;
				owner_q <= owner_q;
			end
		endcase
	end

endmodule

// File: src/ira_stack_cell.sv
module ira_stack_cell #(
	parameter int              ID_BITS = 1,
	parameter logic [ID_BITS-1:0] RST_ID = '0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ira_pkg::stk_op_t   op,
	input  logic               prev_valid,
	input  logic [ID_BITS-1:0] prev_id,
	input  logic               next_valid,
	input  logic [ID_BITS-1:0] next_id,
	output logic               valid,
	output logic [ID_BITS-1:0] id
);

	logic               valid_q;
	logic [ID_BITS-1:0] id_q;

	assign valid = valid_q;
	assign id    = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b1;
			id_q    <= RST_ID;
		end else begin
			case (op)
				ira_pkg::SOP_RESTART: begin
					valid_q <= 1'b1;
					id_q    <= RST_ID;
				end
				ira_pkg::SOP_PUSH: begin
					valid_q <= prev_valid;
					id_q    <= prev_id;
				end
				ira_pkg::SOP_POP: begin
					valid_q <= next_valid;
					id_q    <= next_id;
				end
				default: begin
					valid_q <= valid_q;
					id_q    <= id_q;
				end
			endcase
		end
	end

endmodule

// File: src/interval_resource_allocator_unit.sv
// Greedy interval allocator over a pool of RESOURCES identical resources.
// req (sink): one interval per item: first_of_set, span_start, span_end,
//   item_index. Items must come in nondecreasing span_start order.
// rsp (source): one result per item: result_index, resource_id, impossible.
// Steps: an item is taken while idle, then the busy chain releases one
//   finished entry per cycle (0..RESOURCES entries per item), then a
//   final step allocates and loads the result register, which drives
//   rsp.valid.
// req.ready is high whenever no item is in work, even while a result
//   still waits in the output register.
// If rsp is stalled, the final step waits; nothing is lost or repeated.
// Reset: busy list empty, free stack holds ids 0..RESOURCES-1 with the
//   highest on top, impossible flag clear. first_of_set restores the same
//   state before its interval. Once impossible, the state stays frozen
//   and every result reports impossible with id 0 until first_of_set.
module interval_resource_allocator_unit #(
	parameter int RESOURCES  = ira_pkg::RESOURCES_DEF,
	parameter int TIME_BITS  = ira_pkg::TIME_BITS_DEF,
	parameter int INDEX_BITS = ira_pkg::INDEX_BITS_DEF,
	parameter int ID_BITS    = ira_pkg::ID_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	ira_req_if.sink   req,
	ira_rsp_if.source rsp
);

	`include "interval_resource_allocator_unit_assert.svh"

	ira_pkg::state_t state_q, state_d;

	logic                  imp_q;
	logic [TIME_BITS-1:0]  start_q;
	logic [TIME_BITS-1:0]  end_q;
	logic [INDEX_BITS-1:0] index_q;

	logic                  rsp_valid_q;
	logic [INDEX_BITS-1:0] rsp_index_q;
	logic [ID_BITS-1:0]    rsp_id_q;
	logic                  rsp_imp_q;

	ira_pkg::busy_op_t   bop;
	ira_pkg::stk_op_t    sop;
	ira_pkg::busy_stat_t busy_stat [RESOURCES];
	logic [TIME_BITS-1:0] busy_end  [RESOURCES];
	logic [ID_BITS-1:0]   busy_owner[RESOURCES];
	logic                 stk_valid [RESOURCES];
	logic [ID_BITS-1:0]   stk_id    [RESOURCES];
	logic [RESOURCES-1:0] busy_vld_vec, stk_vld_vec;

	logic accept, out_room, head_rel, finish, set_imp;
	logic [ID_BITS-1:0] fin_id;
	logic               fin_imp;

	assign accept   = req.valid && req.ready;
	assign out_room = !rsp_valid_q || rsp.ready;
	assign head_rel = busy_stat[0].valid && (busy_end[0] <= start_q);

	genvar gi;
	generate
		for (gi = 0; gi < RESOURCES; gi++) begin : g_cell
			ira_pkg::busy_stat_t  p_stat;
			logic [TIME_BITS-1:0] p_end, n_end;
			logic [ID_BITS-1:0]   p_owner, n_owner, sp_id, sn_id;
			logic                 n_valid, sp_valid, sn_valid;

			if (gi == 0) begin : g_head
				assign p_stat   = '0;
				assign p_end    = '0;
				assign p_owner  = '0;
				assign sp_valid = 1'b1;
				assign sp_id    = busy_owner[0];
			end else begin : g_mid
				assign p_stat   = busy_stat[gi-1];
				assign p_end    = busy_end[gi-1];
				assign p_owner  = busy_owner[gi-1];
				assign sp_valid = stk_valid[gi-1];
				assign sp_id    = stk_id[gi-1];
			end

			if (gi == RESOURCES - 1) begin : g_tail
				assign n_valid  = 1'b0;
				assign n_end    = '0;
				assign n_owner  = '0;
				assign sn_valid = 1'b0;
				assign sn_id    = '0;
			end else begin : g_body
				assign n_valid  = busy_stat[gi+1].valid;
				assign n_end    = busy_end[gi+1];
				assign n_owner  = busy_owner[gi+1];
				assign sn_valid = stk_valid[gi+1];
				assign sn_id    = stk_id[gi+1];
			end

			ira_busy_cell #(
				.TIME_BITS (TIME_BITS),
				.ID_BITS   (ID_BITS)
			) u_busy (
				.clk        (clk),
				.arst_n     (arst_n),
				.op         (bop),
				.new_end    (end_q),
				.new_owner  (stk_id[0]),
				.prev_stat  (p_stat),
				.prev_end   (p_end),
				.prev_owner (p_owner),
				.next_valid (n_valid),
				.next_end   (n_end),
				.next_owner (n_owner),
				.stat       (busy_stat[gi]),
				.busy_end   (busy_end[gi]),
				.busy_owner (busy_owner[gi])
			);

			ira_stack_cell #(
				.ID_BITS (ID_BITS),
				.RST_ID  (ID_BITS'(RESOURCES - 1 - gi))
			) u_stk (
				.clk        (clk),
				.arst_n     (arst_n),
				.op         (sop),
				.prev_valid (sp_valid),
				.prev_id    (sp_id),
				.next_valid (sn_valid),
				.next_id    (sn_id),
				.valid      (stk_valid[gi]),
				.id         (stk_id[gi])
			);

			assign busy_vld_vec[gi] = busy_stat[gi].valid;
			assign stk_vld_vec[gi]  = stk_valid[gi];
		end
	endgenerate

	always_comb begin
		state_d   = state_q;
		bop       = ira_pkg::BOP_HOLD;
		sop       = ira_pkg::SOP_HOLD;
		finish    = 1'b0;
		set_imp   = 1'b0;
		fin_id    = '0;
		fin_imp   = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			ira_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ira_pkg::ST_WORK;
					if (req.first_of_set) begin
						bop = ira_pkg::BOP_CLEAR;
						sop = ira_pkg::SOP_RESTART;
					end
				end
			end
			ira_pkg::ST_WORK: begin
				if (imp_q) begin
					fin_imp = 1'b1;
					finish  = out_room;
				end else if (head_rel) begin
					bop = ira_pkg::BOP_SHIFT;
					sop = ira_pkg::SOP_PUSH;
				end else if (!stk_valid[0]) begin
					fin_imp = 1'b1;
					finish  = out_room;
					set_imp = out_room;
				end else begin
					fin_id = stk_id[0];
					finish = out_room;
					if (out_room) begin
						bop = ira_pkg::BOP_INSERT;
						sop = ira_pkg::SOP_POP;
					end
				end
				if (finish) begin
					state_d = ira_pkg::ST_IDLE;
				end
			end
			default: state_d = ira_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ira_pkg::ST_IDLE;
			imp_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && req.first_of_set) begin
				imp_q <= 1'b0;
			end else if (set_imp) begin
				imp_q <= 1'b1;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= req.span_start;
			end_q   <= req.span_end;
			index_q <= req.item_index;
		end
		if (finish) begin
			rsp_index_q <= index_q;
			rsp_id_q    <= fin_id;
			rsp_imp_q   <= fin_imp;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_index = rsp_index_q;
	assign rsp.resource_id  = rsp_id_q;
	assign rsp.impossible   = rsp_imp_q;

	// every resource is either busy or on the free stack
	`IRA_ASSERT_NOW(a_pool_conserved, clk, arst_n, 1'b1,
		($countones(busy_vld_vec) + $countones(stk_vld_vec)) == RESOURCES)

	`IRA_ASSERT_NOW(a_imp_id_zero, clk, arst_n, rsp.valid && rsp.impossible,
		rsp.resource_id == '0)

	`IRA_ASSERT_NEXT(a_accept_starts_work, clk, arst_n, accept,
		(state_q == ira_pkg::ST_WORK) && !req.ready)

	generate
		for (gi = 0; gi + 1 < RESOURCES; gi++) begin : g_chk
			`IRA_ASSERT_NOW(a_busy_sorted, clk, arst_n, busy_stat[gi+1].valid,
				busy_stat[gi].valid && (busy_end[gi] <= busy_end[gi+1]))
		end
	endgenerate

endmodule
